// File: hdl/psfd_pkg.sv
// Shared types, codes and constants for the per-source flood detector.
// Depends on nothing; imported by every module of the block.
package psfd_pkg;

    localparam int FLOW_ENTRIES_DEF  = 64;
    localparam int BLOCK_ENTRIES_DEF = 16;

    localparam logic [1:0] REQ_PACKET  = 2'd0;
    localparam logic [1:0] REQ_BLOCK   = 2'd1;
    localparam logic [1:0] REQ_UNBLOCK = 2'd2;

    localparam logic [1:0] TR_TCP = 2'd1;
    localparam logic [1:0] TR_UDP = 2'd2;

    localparam logic CFG_SYN_THR = 1'b0;
    localparam logic CFG_PKT_THR = 1'b1;

    localparam logic [31:0] SYN_THR_RST = 32'd1000;
    localparam logic [31:0] PKT_THR_RST = 32'd10000;

    localparam logic [7:0] FLAG_FIN = 8'h01;
    localparam logic [7:0] FLAG_SYN = 8'h02;
    localparam logic [7:0] FLAG_RST = 8'h04;
    localparam logic [7:0] FLAG_ACK = 8'h10;

    localparam logic [15:0] PORT_SSH     = 16'd22;
    localparam logic [15:0] PORT_DNS     = 16'd53;
    localparam logic [15:0] PORT_IKE     = 16'd500;
    localparam logic [15:0] PORT_IKE_NAT = 16'd4500;
    localparam logic [15:0] PORT_OVPN    = 16'd1194;
    localparam logic [15:0] PORT_OVPN2   = 16'd41194;
    localparam logic [15:0] PORT_WG      = 16'd51820;

    localparam logic [13:0] RATE_MULT  = 14'd10001;
    localparam logic [31:0] DNS_LIMIT  = 32'd50;
    localparam logic [31:0] RST_LIMIT  = 32'd100;
    localparam logic [15:0] UDP_BIG    = 16'd512;

    typedef enum logic [1:0] {
        ST_PROCESSED = 2'd0,
        ST_DROPPED   = 2'd1,
        ST_FULL      = 2'd2,
        ST_ACK       = 2'd3
    } status_t;

    typedef enum logic [2:0] {
        AL_NONE = 3'd0,
        AL_SYN  = 3'd1,
        AL_VOL  = 3'd2,
        AL_DNS  = 3'd3,
        AL_RST  = 3'd4
    } alert_t;

    typedef enum logic [2:0] {
        TK_NONE    = 3'd0,
        TK_OPENVPN = 3'd1,
        TK_WG      = 3'd2,
        TK_IPSEC   = 3'd3,
        TK_SSH     = 3'd4
    } traffic_t;

    typedef enum logic [3:0] {
        S_IDLE, S_BSCAN, S_BDEC, S_FSCAN, S_UPD, S_CHK, S_EVAL, S_EMIT,
        S_RESP_ACK, S_RESP_FULL, S_RESP_DROP
    } state_t;

    typedef struct packed {
        logic    load;
        logic    bscan_start;
        logic    bwrite;
        logic    bclear;
        logic    fscan_start;
        logic    upd;
        logic    chk;
        logic    eval;
        logic    out_load;
        logic    out_alert;
        status_t out_status;
    } cmd_t;

    typedef struct packed {
        logic [1:0] req;
        logic       bdone;
        logic       bhit;
        logic       bfree;
        logic       bexpired;
        logic       fdone;
        logic       fhit;
        logic       ffree;
        logic       out_free;
        logic       emit_last;
    } stat_t;

    typedef struct packed {
        logic [31:0] key;
        logic [31:0] first_t;
        logic [31:0] last_t;
        logic [31:0] pkts;
        logic [47:0] bytes;
        logic [31:0] syn;
        logic [31:0] ack;
        logic [31:0] fin;
        logic [31:0] rst;
        logic [31:0] dns;
        logic [31:0] udp;
        logic [1:0]  threat;
        logic [2:0]  traffic;
    } flow_rec_t;

    function automatic logic [31:0] sat_add32(input logic [31:0] v, input logic [31:0] d);
        logic [32:0] s;
        s = {1'b0, v} + {1'b0, d};
        return s[32] ? 32'hFFFF_FFFF : s[31:0];
    endfunction

    function automatic logic [1:0] alert_level(input alert_t k);
        logic [1:0] l;
        case (k)
            AL_SYN:  l = 2'd2;
            AL_VOL:  l = 2'd2;
            AL_DNS:  l = 2'd3;
            AL_RST:  l = 2'd1;
            default: l = 2'd0;
        endcase
        return l;
    endfunction

endpackage

// File: hdl/psfd_ctrl.sv
// Sequencer of the flood detector: scans, update steps and result emission.
// Depends on psfd_pkg; drives psfd_dp through cmd_t and reads stat_t.
module psfd_ctrl
    import psfd_pkg::*;
(
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_valid,
    output logic  s_ready,
    input  stat_t st,
    output cmd_t  cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE: begin
                if (s_valid) state_next = S_BSCAN;
            end
            S_BSCAN: begin
                if (st.bdone) state_next = S_BDEC;
            end
            S_BDEC: begin
                if (st.req == REQ_BLOCK) begin
                    state_next = (st.bhit || st.bfree) ? S_RESP_ACK : S_RESP_FULL;
                end else if (st.req != REQ_PACKET) begin
                    state_next = S_RESP_ACK;
                end else if (st.bhit && !st.bexpired) begin
                    state_next = S_RESP_DROP;
                end else begin
                    state_next = S_FSCAN;
                end
            end
            S_FSCAN: begin
                if (st.fdone) state_next = (st.fhit || st.ffree) ? S_UPD : S_RESP_FULL;
            end
            S_UPD:  state_next = S_CHK;
            S_CHK:  state_next = S_EVAL;
            S_EVAL: state_next = S_EMIT;
            S_EMIT: begin
                if (st.out_free && st.emit_last) state_next = S_IDLE;
            end
            S_RESP_ACK, S_RESP_FULL, S_RESP_DROP: begin
                if (st.out_free) state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        cmd = '0;
        cmd.out_status = ST_PROCESSED;
        s_ready = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                s_ready         = 1'b1;
                cmd.load        = s_valid;
                cmd.bscan_start = s_valid;
            end
            S_BSCAN: ;
            S_BDEC: begin
                if (st.req == REQ_BLOCK) begin
                    cmd.bwrite = st.bhit || st.bfree;
                end else if (st.req == REQ_UNBLOCK) begin
                    cmd.bclear = 1'b1;
                end else if (st.req == REQ_PACKET && !(st.bhit && !st.bexpired)) begin
                    cmd.bclear      = 1'b1;
                    cmd.fscan_start = 1'b1;
                end
            end
            S_FSCAN: ;
            S_UPD:  cmd.upd  = 1'b1;
            S_CHK:  cmd.chk  = 1'b1;
            S_EVAL: cmd.eval = 1'b1;
            S_EMIT: begin
                cmd.out_load  = st.out_free;
                cmd.out_alert = 1'b1;
            end
            S_RESP_ACK: begin
                cmd.out_load   = st.out_free;
                cmd.out_status = ST_ACK;
            end
            S_RESP_FULL: begin
                cmd.out_load   = st.out_free;
                cmd.out_status = ST_FULL;
            end
            S_RESP_DROP: begin
                cmd.out_load   = st.out_free;
                cmd.out_status = ST_DROPPED;
            end
            default: ;
        endcase
    end

    ap_scan_start_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.bscan_start |-> state_reg == S_IDLE)
        else $error("block scan started outside idle");
    ap_eval_to_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |=> state_reg == S_EMIT)
        else $error("evaluation not followed by emission");
    ap_load_once: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |=> !s_ready)
        else $error("request accepted while busy");

endmodule

// File: hdl/psfd_dp.sv
// Datapath: request registers, block and flow tables, scans, update and output register.
// Depends on psfd_pkg; commanded by psfd_ctrl.
module psfd_dp
    import psfd_pkg::*;
#(
    parameter int FLOW_ENTRIES  = FLOW_ENTRIES_DEF,
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cmd_t        cmd,
    output stat_t       st,
    input  logic [31:0] syn_thr,
    input  logic [31:0] pkt_thr,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_now_time,
    input  logic [31:0] s_pkt_time,
    input  logic [1:0]  s_transport,
    input  logic [15:0] s_src_port,
    input  logic [15:0] s_dst_port,
    input  logic [15:0] s_packet_size,
    input  logic [15:0] s_payload_len,
    input  logic [7:0]  s_tcp_flags,
    input  logic [7:0]  s_ike_next_payload,
    input  logic [31:0] s_block_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_alert_kind,
    output logic [1:0]  m_alert_level,
    output logic [1:0]  m_entry_threat,
    output logic [2:0]  m_traffic_kind,
    output logic [31:0] m_entry_packets,
    output logic        m_last
);

    localparam int FW = (FLOW_ENTRIES > 1) ? $clog2(FLOW_ENTRIES) : 1;
    localparam int BW = (BLOCK_ENTRIES > 1) ? $clog2(BLOCK_ENTRIES) : 1;
    localparam logic [BW:0] BE_CNT = (BW+1)'(BLOCK_ENTRIES);

    // latched request
    logic [1:0]  req_reg;
    logic [31:0] ip_reg, now_reg, ptime_reg, secs_reg;
    logic [1:0]  tr_reg;
    logic [15:0] sport_reg, dport_reg, psize_reg, plen_reg;
    logic [7:0]  flags_reg, ike_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            req_reg   <= s_req_type;
            ip_reg    <= s_src_ip;
            now_reg   <= s_now_time;
            ptime_reg <= s_pkt_time;
            secs_reg  <= s_block_seconds;
            tr_reg    <= s_transport;
            sport_reg <= s_src_port;
            dport_reg <= s_dst_port;
            psize_reg <= s_packet_size;
            plen_reg  <= s_payload_len;
            flags_reg <= s_tcp_flags;
            ike_reg   <= s_ike_next_payload;
        end
    end

    // ---------------- block table ----------------
    logic [63:0]            bmem [BLOCK_ENTRIES];
    logic [BLOCK_ENTRIES-1:0] bvalid_reg;
    logic [BW:0]   bcnt_reg;
    logic          bpv_reg, bval_q_reg;
    logic [BW-1:0] bidx_q_reg;
    logic [63:0]   brd_reg;
    logic          bhit_reg, bfree_reg;
    logic [BW-1:0] bhit_idx_reg, bfree_idx_reg;
    logic [31:0]   buntil_reg;
    logic          bissue;
    logic [BW-1:0] bwidx;
    logic [32:0]   rel_sum;

    assign bissue  = (bcnt_reg != BE_CNT) && !bhit_reg;
    assign bwidx   = bhit_reg ? bhit_idx_reg : bfree_idx_reg;
    assign rel_sum = {1'b0, now_reg} + {1'b0, secs_reg};

    always_ff @(posedge aclk) begin
        if (bissue) brd_reg <= bmem[bcnt_reg[BW-1:0]];
        if (cmd.bwrite) bmem[bwidx] <= {ip_reg, rel_sum[32] ? 32'hFFFF_FFFF : rel_sum[31:0]};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bvalid_reg <= '0;
            bcnt_reg   <= BE_CNT;
            bpv_reg    <= 1'b0;
            bhit_reg   <= 1'b0;
            bfree_reg  <= 1'b0;
        end else begin
            if (cmd.bscan_start) begin
                bcnt_reg  <= '0;
                bpv_reg   <= 1'b0;
                bhit_reg  <= 1'b0;
                bfree_reg <= 1'b0;
            end else begin
                bpv_reg <= bissue;
                if (bissue) bcnt_reg <= bcnt_reg + 1'b1;
                if (bpv_reg && !bhit_reg) begin
                    if (bval_q_reg && brd_reg[63:32] == ip_reg) begin
                        bhit_reg <= 1'b1;
                    end else if (!bval_q_reg && !bfree_reg) begin
                        bfree_reg <= 1'b1;
                    end
                end
            end
            if (cmd.bwrite) bvalid_reg[bwidx] <= 1'b1;
            if (cmd.bclear && bhit_reg) bvalid_reg[bhit_idx_reg] <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (bissue) begin
            bidx_q_reg <= bcnt_reg[BW-1:0];
            bval_q_reg <= bvalid_reg[bcnt_reg[BW-1:0]];
        end
        if (!cmd.bscan_start && bpv_reg && !bhit_reg) begin
            if (bval_q_reg && brd_reg[63:32] == ip_reg) begin
                bhit_idx_reg <= bidx_q_reg;
                buntil_reg   <= brd_reg[31:0];
            end else if (!bval_q_reg && !bfree_reg) begin
                bfree_idx_reg <= bidx_q_reg;
            end
        end
    end

    // ---------------- flow table ----------------
    flow_rec_t              fmem [FLOW_ENTRIES];
    logic [FLOW_ENTRIES-1:0] fvalid_reg;
    logic [FW:0]   fcnt_reg;
    logic          fpv_reg, fval_q_reg;
    logic [FW-1:0] fidx_q_reg;
    flow_rec_t     frd_reg, frec_reg;
    logic          fhit_reg, ffree_reg;
    logic [FW-1:0] fhit_idx_reg, ffree_idx_reg, widx_reg;
    logic          fissue;
    flow_rec_t     wrec;

    assign fissue = (fcnt_reg != (FW+1)'(FLOW_ENTRIES)) && !fhit_reg;

    always_ff @(posedge aclk) begin
        if (fissue) frd_reg <= fmem[fcnt_reg[FW-1:0]];
        if (cmd.eval) fmem[widx_reg] <= wrec;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fvalid_reg <= '0;
            fcnt_reg   <= (FW+1)'(FLOW_ENTRIES);
            fpv_reg    <= 1'b0;
            fhit_reg   <= 1'b0;
            ffree_reg  <= 1'b0;
        end else begin
            if (cmd.fscan_start) begin
                fcnt_reg  <= '0;
                fpv_reg   <= 1'b0;
                fhit_reg  <= 1'b0;
                ffree_reg <= 1'b0;
            end else begin
                fpv_reg <= fissue;
                if (fissue) fcnt_reg <= fcnt_reg + 1'b1;
                if (fpv_reg && !fhit_reg) begin
                    if (fval_q_reg && frd_reg.key == ip_reg) begin
                        fhit_reg <= 1'b1;
                    end else if (!fval_q_reg && !ffree_reg) begin
                        ffree_reg <= 1'b1;
                    end
                end
            end
            if (cmd.eval) fvalid_reg[widx_reg] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (fissue) begin
            fidx_q_reg <= fcnt_reg[FW-1:0];
            fval_q_reg <= fvalid_reg[fcnt_reg[FW-1:0]];
        end
        if (!cmd.fscan_start && fpv_reg && !fhit_reg) begin
            if (fval_q_reg && frd_reg.key == ip_reg) begin
                fhit_idx_reg <= fidx_q_reg;
                frec_reg     <= frd_reg;
            end else if (!fval_q_reg && !ffree_reg) begin
                ffree_idx_reg <= fidx_q_reg;
            end
        end
    end

    // ---------------- update: counters and traffic mark ----------------
    flow_rec_t   base, nrec_next, nrec_reg;
    traffic_t    kind;
    logic [48:0] byte_sum;

    always_comb begin
        if (fhit_reg) begin
            base = frec_reg;
        end else begin
            base         = '0;
            base.key     = ip_reg;
            base.first_t = ptime_reg;
        end
        nrec_next        = base;
        nrec_next.last_t = ptime_reg;
        nrec_next.pkts   = sat_add32(base.pkts, 32'd1);
        byte_sum         = {1'b0, base.bytes} + {33'd0, psize_reg};
        nrec_next.bytes  = byte_sum[48] ? 48'hFFFF_FFFF_FFFF : byte_sum[47:0];

        kind = TK_NONE;
        if (dport_reg == PORT_OVPN || dport_reg == PORT_OVPN2) begin
            kind = TK_OPENVPN;
        end else if (dport_reg == PORT_WG && tr_reg == TR_UDP) begin
            kind = TK_WG;
        end else if ((dport_reg == PORT_IKE || dport_reg == PORT_IKE_NAT) &&
                     plen_reg >= 16'd8 && (ike_reg == 8'd0 || ike_reg == 8'd17)) begin
            kind = TK_IPSEC;
        end else if (tr_reg == TR_TCP && sport_reg == PORT_SSH) begin
            kind = TK_SSH;
        end
        if (kind != TK_NONE) begin
            nrec_next.traffic = kind;
            if (base.threat == 2'd0) nrec_next.threat = 2'd1;
        end

        if (tr_reg == TR_TCP) begin
            if (plen_reg >= 16'd14) begin
                if ((flags_reg & FLAG_SYN) != '0) nrec_next.syn = sat_add32(base.syn, 32'd1);
                if ((flags_reg & FLAG_ACK) != '0) nrec_next.ack = sat_add32(base.ack, 32'd1);
                if ((flags_reg & FLAG_FIN) != '0) nrec_next.fin = sat_add32(base.fin, 32'd1);
                if ((flags_reg & FLAG_RST) != '0) nrec_next.rst = sat_add32(base.rst, 32'd1);
            end
        end else if (tr_reg == TR_UDP) begin
            if (dport_reg == PORT_DNS) nrec_next.dns = sat_add32(base.dns, 32'd1);
            nrec_next.udp = sat_add32(base.udp, (plen_reg > UDP_BIG) ? 32'd2 : 32'd1);
        end
    end

    // ---------------- check: products for the alert compares ----------------
    logic [31:0] dur;
    logic [45:0] vol_prod_reg;
    logic [35:0] ack10_reg;
    logic [34:0] rst5_reg;
    logic        dur_nz_reg;

    assign dur = (nrec_reg.last_t > nrec_reg.first_t) ? nrec_reg.last_t - nrec_reg.first_t
                                                      : 32'd0;

    always_ff @(posedge aclk) begin
        if (cmd.upd) begin
            nrec_reg <= nrec_next;
            widx_reg <= fhit_reg ? fhit_idx_reg : ffree_idx_reg;
        end
        if (cmd.chk) begin
            vol_prod_reg <= 46'(dur) * 46'(RATE_MULT);
            ack10_reg    <= {1'b0, nrec_reg.ack, 3'b0} + {3'b0, nrec_reg.ack, 1'b0};
            rst5_reg     <= {1'b0, nrec_reg.rst, 2'b0} + {3'b0, nrec_reg.rst};
            dur_nz_reg   <= dur != 32'd0;
        end
    end

    // ---------------- evaluate: alerts and final threat ----------------
    logic       syn_al, vol_al, dns_al, rst_al;
    alert_t     kinds_next [3];
    alert_t     kinds_reg  [3];
    logic [1:0] n_next, n_reg, k_reg;

    always_comb begin
        syn_al = nrec_reg.syn > syn_thr && (ack10_reg + 36'd10) <= {4'b0, nrec_reg.syn};
        vol_al = nrec_reg.pkts > pkt_thr && dur_nz_reg && {14'b0, nrec_reg.pkts} >= vol_prod_reg;
        dns_al = nrec_reg.dns > DNS_LIMIT;
        rst_al = nrec_reg.rst > RST_LIMIT && {3'b0, nrec_reg.ack} > rst5_reg;
        wrec   = nrec_reg;
        n_next = 2'd0;
        for (int i = 0; i < 3; i++) kinds_next[i] = AL_NONE;
        if (syn_al) begin
            kinds_next[0] = AL_SYN;
            n_next        = 2'd1;
            wrec.threat   = 2'd2;
        end else begin
            if (vol_al) begin
                kinds_next[n_next] = AL_VOL;
                n_next             = n_next + 2'd1;
                wrec.threat        = 2'd2;
            end
            if (dns_al) begin
                kinds_next[n_next] = AL_DNS;
                n_next             = n_next + 2'd1;
                wrec.threat        = 2'd3;
            end
            if (rst_al) begin
                kinds_next[n_next] = AL_RST;
                n_next             = n_next + 2'd1;
                wrec.threat        = 2'd1;
            end
        end
    end

    logic [1:0]  res_threat_reg;
    logic [2:0]  res_traffic_reg;
    logic [31:0] res_pkts_reg;

    always_ff @(posedge aclk) begin
        if (cmd.eval) begin
            kinds_reg       <= kinds_next;
            n_reg           <= n_next;
            res_threat_reg  <= wrec.threat;
            res_traffic_reg <= wrec.traffic;
            res_pkts_reg    <= wrec.pkts;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            k_reg <= 2'd0;
        end else if (cmd.eval) begin
            k_reg <= 2'd0;
        end else if (cmd.out_load && cmd.out_alert) begin
            k_reg <= k_reg + 2'd1;
        end
    end

    // ---------------- output register ----------------
    logic   m_valid_reg;
    alert_t cur_kind;

    assign cur_kind = (n_reg == 2'd0) ? AL_NONE : kinds_reg[k_reg];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            if (cmd.out_alert) begin
                m_status        <= ST_PROCESSED;
                m_alert_kind    <= cur_kind;
                m_alert_level   <= alert_level(cur_kind);
                m_entry_threat  <= res_threat_reg;
                m_traffic_kind  <= res_traffic_reg;
                m_entry_packets <= res_pkts_reg;
                m_last          <= st.emit_last;
            end else begin
                m_status        <= cmd.out_status;
                m_alert_kind    <= AL_NONE;
                m_alert_level   <= 2'd0;
                m_entry_threat  <= 2'd0;
                m_traffic_kind  <= TK_NONE;
                m_entry_packets <= 32'd0;
                m_last          <= 1'b1;
            end
        end
    end

    assign m_valid = m_valid_reg;

    always_comb begin
        st.req       = req_reg;
        st.bdone     = bhit_reg || (bcnt_reg == BE_CNT && !bpv_reg);
        st.bhit      = bhit_reg;
        st.bfree     = bfree_reg;
        st.bexpired  = now_reg > buntil_reg;
        st.fdone     = fhit_reg || (fcnt_reg == (FW+1)'(FLOW_ENTRIES) && !fpv_reg);
        st.fhit      = fhit_reg;
        st.ffree     = ffree_reg;
        st.out_free  = !m_valid_reg || m_ready;
        st.emit_last = (n_reg == 2'd0) || (k_reg == n_reg - 2'd1);
    end

    ap_flow_written: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.eval |=> fvalid_reg[$past(widx_reg)])
        else $error("flow entry not valid after write");
    ap_out_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before taken");
    ap_fhit_key: assert property (@(posedge aclk) disable iff (!aresetn)
        (fhit_reg && cmd.upd) |-> frec_reg.key == ip_reg)
        else $error("flow hit with wrong key");

endmodule

// File: hdl/per_source_flood_detector_core.sv
// Top level of the per-source flood detector: configuration registers and wiring.
// Depends on psfd_pkg, psfd_ctrl and psfd_dp.
//
//  channel  | handshake            | payload
//  ---------+----------------------+-------------------------------------------
//  s_*      | s_valid / s_ready    | req_type .. block_seconds, one request
//  m_*      | m_valid / m_ready    | status .. last, one to three results
//  cfg_*    | cfg_wr_en            | cfg_index, cfg_wdata (thresholds)
//
// Block scan: one RAM read per cycle over BLOCK_ENTRIES, then compare and drain, then a
// decision state; packets then scan the flow table the same way and go through the
// update, check (multiply) and evaluate states. Scans stop early on a hit. A packet
// that misses both tables scans every block and flow entry before its update.
// Reset clears the valid bits at once, no clearing pass.
// A low m_ready holds the result register and the sequencer; one request in flight.
module per_source_flood_detector_core
    import psfd_pkg::*;
#(
    parameter int FLOW_ENTRIES  = FLOW_ENTRIES_DEF,
    parameter int BLOCK_ENTRIES = BLOCK_ENTRIES_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic        cfg_index,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_req_type,
    input  logic [31:0] s_src_ip,
    input  logic [31:0] s_now_time,
    input  logic [31:0] s_pkt_time,
    input  logic [1:0]  s_transport,
    input  logic [15:0] s_src_port,
    input  logic [15:0] s_dst_port,
    input  logic [15:0] s_packet_size,
    input  logic [15:0] s_payload_len,
    input  logic [7:0]  s_tcp_flags,
    input  logic [7:0]  s_ike_next_payload,
    input  logic [31:0] s_block_seconds,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [1:0]  m_status,
    output logic [2:0]  m_alert_kind,
    output logic [1:0]  m_alert_level,
    output logic [1:0]  m_entry_threat,
    output logic [2:0]  m_traffic_kind,
    output logic [31:0] m_entry_packets,
    output logic        m_last
);

    // threshold registers; the user must write them only while idle, the block does not enforce it
    logic [31:0] syn_thr_reg, pkt_thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            syn_thr_reg <= SYN_THR_RST;
            pkt_thr_reg <= PKT_THR_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_SYN_THR: syn_thr_reg <= cfg_wdata;
                CFG_PKT_THR: pkt_thr_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    cmd_t  cmd;
    stat_t st;

    // sequencer: owns the request handshake
    psfd_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .st      (st),
        .cmd     (cmd)
    );

    // tables, counters, alert logic and the result register
    psfd_dp #(
        .FLOW_ENTRIES  (FLOW_ENTRIES),
        .BLOCK_ENTRIES (BLOCK_ENTRIES)
    ) u_dp (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .cmd                (cmd),
        .st                 (st),
        .syn_thr            (syn_thr_reg),
        .pkt_thr            (pkt_thr_reg),
        .s_req_type         (s_req_type),
        .s_src_ip           (s_src_ip),
        .s_now_time         (s_now_time),
        .s_pkt_time         (s_pkt_time),
        .s_transport        (s_transport),
        .s_src_port         (s_src_port),
        .s_dst_port         (s_dst_port),
        .s_packet_size      (s_packet_size),
        .s_payload_len      (s_payload_len),
        .s_tcp_flags        (s_tcp_flags),
        .s_ike_next_payload (s_ike_next_payload),
        .s_block_seconds    (s_block_seconds),
        .m_valid            (m_valid),
        .m_ready            (m_ready),
        .m_status           (m_status),
        .m_alert_kind       (m_alert_kind),
        .m_alert_level      (m_alert_level),
        .m_entry_threat     (m_entry_threat),
        .m_traffic_kind     (m_traffic_kind),
        .m_entry_packets    (m_entry_packets),
        .m_last             (m_last)
    );

endmodule

// File: bench/tb.sv
// Self-checking bench for per_source_flood_detector_core: directed and random requests,
// a flow-table predictor in a small scoreboard class, random idling on both channels.
// Depends on psfd_pkg and the RTL of the block.
module tb;
    import psfd_pkg::*;

    localparam int N_FLOW      = 64;
    localparam int N_BLOCK     = 16;
    localparam int STALL_LIMIT = 2000;   // cycles without any handshake
    localparam int DRAIN_WAIT  = 120;    // > one full request pass through the block

    typedef struct {
        logic [1:0]  req;
        logic [31:0] ip;
        logic [31:0] now;
        logic [31:0] ptime;
        logic [1:0]  tr;
        logic [15:0] sport;
        logic [15:0] dport;
        logic [15:0] psize;
        logic [15:0] plen;
        logic [7:0]  flags;
        logic [7:0]  ike;
        logic [31:0] secs;
    } flood_req_t;

    typedef struct {
        status_t     st;
        alert_t      ak;
        logic [1:0]  al;
        logic [1:0]  th;
        traffic_t    tk;
        logic [31:0] pk;
        logic        last;
    } verdict_t;

    // Predictor of the block plus the queue of verdicts still owed by the DUT.
    class flood_scoreboard;
        bit          fv[N_FLOW];
        logic [31:0] fkey[N_FLOW], t_first[N_FLOW], t_last[N_FLOW], pkts[N_FLOW];
        logic [47:0] bytes[N_FLOW];
        logic [31:0] syn[N_FLOW], ack[N_FLOW], fin[N_FLOW], rst[N_FLOW];
        logic [31:0] dns[N_FLOW], udp[N_FLOW];
        logic [1:0]  threat[N_FLOW];
        traffic_t    tmark[N_FLOW];
        bit          bv[N_BLOCK];
        logic [31:0] bkey[N_BLOCK], buntil[N_BLOCK];
        logic [31:0] syn_thr, pkt_thr;
        verdict_t    owed[$];
        int          errors;

        function new();
            syn_thr = SYN_THR_RST;
            pkt_thr = PKT_THR_RST;
            errors  = 0;
        endfunction

        function logic [31:0] sat_inc(logic [31:0] v, logic [31:0] d);
            logic [32:0] s;
            s = {1'b0, v} + {1'b0, d};
            return s[32] ? 32'hFFFF_FFFF : s[31:0];
        endfunction

        function void owe(status_t st, alert_t ak, logic [1:0] al, logic [1:0] th,
                          traffic_t tk, logic [31:0] pk, logic last);
            verdict_t v;
            v.st = st; v.ak = ak; v.al = al; v.th = th; v.tk = tk; v.pk = pk;
            v.last = last;
            owed = {owed, v};
        endfunction

        function int find_block(logic [31:0] ip);
            for (int i = 0; i < N_BLOCK; i++)
                if (bv[i] && bkey[i] == ip) return i;
            return -1;
        endfunction

        // Called once per accepted request; queues the verdicts it must produce.
        function void note_request(flood_req_t r);
            int          b, e, n;
            alert_t      kinds[3];
            logic [1:0]  lvls[3];
            traffic_t    kind;
            logic [31:0] dur;
            logic [48:0] bsum;
            b = find_block(r.ip);
            e = -1;
            n = 0;
            if (r.req == REQ_BLOCK) begin
                if (b < 0)
                    for (int i = N_BLOCK - 1; i >= 0; i--)
                        if (!bv[i]) b = i;
                if (b < 0) begin
                    owe(ST_FULL, AL_NONE, 2'd0, 2'd0, TK_NONE, 32'd0, 1'b1);
                    return;
                end
                bv[b] = 1; bkey[b] = r.ip; buntil[b] = sat_inc(r.now, r.secs);
                owe(ST_ACK, AL_NONE, 2'd0, 2'd0, TK_NONE, 32'd0, 1'b1);
                return;
            end
            if (r.req != REQ_PACKET) begin
                if (r.req == REQ_UNBLOCK && b >= 0) bv[b] = 0;
                owe(ST_ACK, AL_NONE, 2'd0, 2'd0, TK_NONE, 32'd0, 1'b1);
                return;
            end
            // blocked source: drop until the release time has passed
            if (b >= 0) begin
                if (r.now > buntil[b]) bv[b] = 0;
                else begin
                    owe(ST_DROPPED, AL_NONE, 2'd0, 2'd0, TK_NONE, 32'd0, 1'b1);
                    return;
                end
            end
            for (int i = N_FLOW - 1; i >= 0; i--)
                if (fv[i] && fkey[i] == r.ip) e = i;
            if (e < 0) begin
                for (int i = N_FLOW - 1; i >= 0; i--)
                    if (!fv[i]) e = i;
                if (e < 0) begin
                    owe(ST_FULL, AL_NONE, 2'd0, 2'd0, TK_NONE, 32'd0, 1'b1);
                    return;
                end
                fv[e] = 1; fkey[e] = r.ip; t_first[e] = r.ptime;
                pkts[e] = '0; bytes[e] = '0; syn[e] = '0; ack[e] = '0; fin[e] = '0;
                rst[e] = '0; dns[e] = '0; udp[e] = '0; threat[e] = 2'd0; tmark[e] = TK_NONE;
            end
            t_last[e] = r.ptime;
            pkts[e]   = sat_inc(pkts[e], 32'd1);
            bsum      = {1'b0, bytes[e]} + {33'd0, r.psize};
            bytes[e]  = bsum[48] ? 48'hFFFF_FFFF_FFFF : bsum[47:0];

            kind = TK_NONE;
            if (r.dport == PORT_OVPN || r.dport == PORT_OVPN2) kind = TK_OPENVPN;
            else if (r.dport == PORT_WG && r.tr == TR_UDP) kind = TK_WG;
            else if ((r.dport == PORT_IKE || r.dport == PORT_IKE_NAT) && r.plen >= 8 &&
                     (r.ike == 8'd0 || r.ike == 8'd17)) kind = TK_IPSEC;
            else if (r.tr == TR_TCP && r.sport == PORT_SSH) kind = TK_SSH;
            if (kind != TK_NONE) begin
                tmark[e] = kind;
                if (threat[e] < 1) threat[e] = 2'd1;
            end

            if (r.tr == TR_TCP) begin
                if (r.plen >= 14) begin
                    if (r.flags & FLAG_SYN) syn[e] = sat_inc(syn[e], 32'd1);
                    if (r.flags & FLAG_ACK) ack[e] = sat_inc(ack[e], 32'd1);
                    if (r.flags & FLAG_FIN) fin[e] = sat_inc(fin[e], 32'd1);
                    if (r.flags & FLAG_RST) rst[e] = sat_inc(rst[e], 32'd1);
                end
            end else if (r.tr == TR_UDP) begin
                if (r.dport == PORT_DNS) dns[e] = sat_inc(dns[e], 32'd1);
                udp[e] = sat_inc(udp[e], (r.plen > UDP_BIG) ? 32'd2 : 32'd1);
            end

            // SYN flood ends detection; otherwise the later alerts overwrite the threat
            if (syn[e] > syn_thr && ack[e] < syn[e] / 10) begin
                threat[e] = 2'd2; kinds[n] = AL_SYN; lvls[n] = 2'd2; n++;
            end else begin
                if (pkts[e] > pkt_thr) begin
                    dur = (t_last[e] > t_first[e]) ? t_last[e] - t_first[e] : 32'd0;
                    if (dur != 0 && 64'(pkts[e]) >= 64'd10001 * 64'(dur)) begin
                        threat[e] = 2'd2; kinds[n] = AL_VOL; lvls[n] = 2'd2; n++;
                    end
                end
                if (dns[e] > DNS_LIMIT) begin
                    threat[e] = 2'd3; kinds[n] = AL_DNS; lvls[n] = 2'd3; n++;
                end
                if (rst[e] > RST_LIMIT && 64'(ack[e]) > 64'(rst[e]) * 64'd5) begin
                    threat[e] = 2'd1; kinds[n] = AL_RST; lvls[n] = 2'd1; n++;
                end
            end
            if (n == 0) owe(ST_PROCESSED, AL_NONE, 2'd0, threat[e], tmark[e], pkts[e], 1'b1);
            for (int i = 0; i < n; i++)
                owe(ST_PROCESSED, kinds[i], lvls[i], threat[e], tmark[e], pkts[e],
                    i == n - 1);
        endfunction

        task report_mismatch(string msg);
            errors++;
            $display("MISMATCH @%0t: %s", $time, msg);
        endtask

        task check_result(logic [1:0] st, logic [2:0] ak, logic [1:0] al, logic [1:0] th,
                          logic [2:0] tk, logic [31:0] pk, logic last);
            verdict_t v;
            if (owed.size() == 0) begin
                report_mismatch($sformatf("unexpected result st=%0d ak=%0d", st, ak));
                return;
            end
            v = owed.pop_front();
            if (st !== v.st || ak !== v.ak || al !== v.al || th !== v.th ||
                tk !== v.tk || pk !== v.pk || last !== v.last)
                report_mismatch($sformatf(
                    "got st%0d ak%0d al%0d th%0d tk%0d pk%0d l%0d, want %0d %0d %0d %0d %0d %0d %0d",
                    st, ak, al, th, tk, pk, last,
                    v.st, v.ak, v.al, v.th, v.tk, v.pk, v.last));
        endtask
    endclass

    logic        aclk, aresetn;
    logic        cfg_wr_en, cfg_index;
    logic [31:0] cfg_wdata;
    logic        s_valid, s_ready;
    logic [1:0]  s_req_type, s_transport;
    logic [31:0] s_src_ip, s_now_time, s_pkt_time, s_block_seconds;
    logic [15:0] s_src_port, s_dst_port, s_packet_size, s_payload_len;
    logic [7:0]  s_tcp_flags, s_ike_next_payload;
    logic        m_valid, m_ready, m_last;
    logic [1:0]  m_status, m_alert_level, m_entry_threat;
    logic [2:0]  m_alert_kind, m_traffic_kind;
    logic [31:0] m_entry_packets;

    per_source_flood_detector_core dut (.*);

    flood_scoreboard sb = new();
    int tx_idle_pct = 0;
    int rx_idle_pct = 0;
    int quiet_cycles = 0;

    localparam logic [31:0] HOT_IP  = 32'h0A63_0001;   // source revisited in the last phase
    localparam logic [31:0] POOL_IP = 32'h0A00_0000;   // small pool of recurring sources

    initial begin
        aclk = 1'b0;
        forever #1 aclk = ~aclk;
    end

    // Result side: random back-pressure, then check every accepted result.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_idle_pct);
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_status, m_alert_kind, m_alert_level, m_entry_threat,
                            m_traffic_kind, m_entry_packets, m_last);
    end

    // Watchdog: a run with no handshake for too long is a hang.
    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= STALL_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Present one request and hold it until accepted; valid stays high across
    // back-to-back requests unless the sender decides to idle.
    task automatic push(flood_req_t r);
        if ($urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct) @(posedge aclk);
        end
        s_valid            <= 1'b1;
        s_req_type         <= r.req;
        s_src_ip           <= r.ip;
        s_now_time         <= r.now;
        s_pkt_time         <= r.ptime;
        s_transport        <= r.tr;
        s_src_port         <= r.sport;
        s_dst_port         <= r.dport;
        s_packet_size      <= r.psize;
        s_payload_len      <= r.plen;
        s_tcp_flags        <= r.flags;
        s_ike_next_payload <= r.ike;
        s_block_seconds    <= r.secs;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        sb.note_request(r);
    endtask

    // Wait for every owed result, then give the block time to go idle.
    task automatic drain();
        s_valid <= 1'b0;
        while (sb.owed.size() != 0) @(posedge aclk);
        repeat (DRAIN_WAIT) @(posedge aclk);
    endtask

    // Thresholds are only written with the block idle (after reset or a drain).
    task automatic set_thresholds(logic [31:0] syn_thr, logic [31:0] pkt_thr);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_SYN_THR;
        cfg_wdata <= syn_thr;
        @(posedge aclk);
        cfg_index <= CFG_PKT_THR;
        cfg_wdata <= pkt_thr;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        sb.syn_thr = syn_thr;
        sb.pkt_thr = pkt_thr;
    endtask

    function automatic flood_req_t pkt(logic [31:0] ip, logic [1:0] tr, logic [15:0] dport,
                                       logic [15:0] plen, logic [7:0] flags);
        flood_req_t r;
        r.req = REQ_PACKET; r.ip = ip; r.now = 32'd10; r.ptime = 32'd1000; r.tr = tr;
        r.sport = 16'd40000; r.dport = dport; r.psize = 16'd64; r.plen = plen;
        r.flags = flags; r.ike = 8'hFF; r.secs = '0;
        return r;
    endfunction

    function automatic flood_req_t ctl(logic [1:0] req, logic [31:0] ip, logic [31:0] now,
                                       logic [31:0] secs);
        flood_req_t r;
        r = pkt(ip, 2'd0, 16'd0, 16'd0, 8'd0);
        r.req = req; r.now = now; r.secs = secs;
        return r;
    endfunction

    // Mostly packets from a small source pool with biased ports and times,
    // so that blocks, expiries, VPN marks and SYN floods keep recurring.
    function automatic flood_req_t random_req();
        flood_req_t r;
        int         pick;
        logic [15:0] ports[8] = '{PORT_SSH, PORT_DNS, PORT_IKE, PORT_IKE_NAT,
                                  PORT_OVPN, PORT_OVPN2, PORT_WG, 16'd80};
        pick   = $urandom_range(99);
        r.req  = (pick < 80) ? REQ_PACKET : (pick < 88) ? REQ_BLOCK :
                 (pick < 96) ? REQ_UNBLOCK : 2'd3;
        r.ip   = ($urandom_range(4) == 0) ? $urandom : POOL_IP + $urandom_range(11);
        r.now  = ($urandom_range(9) == 0) ? $urandom : $urandom_range(2000);
        r.secs = ($urandom_range(9) == 0) ? $urandom : $urandom_range(500);
        r.ptime = ($urandom_range(4) == 0) ? $urandom : 32'd1000 + $urandom_range(3);
        r.tr    = 2'($urandom_range(3));
        r.sport = ($urandom_range(3) == 0) ? PORT_SSH : 16'($urandom_range(65535));
        r.dport = ($urandom_range(1) == 0) ? ports[$urandom_range(7)]
                                           : 16'($urandom_range(65535));
        r.psize = 16'($urandom_range(65535));
        r.plen  = ($urandom_range(1) == 0) ? 16'($urandom_range(20))
                                           : 16'($urandom_range(65535));
        r.flags = ($urandom_range(1) == 0) ? FLAG_SYN : 8'($urandom_range(255));
        r.ike   = ($urandom_range(1) == 0) ? 8'd0 + 8'($urandom_range(1) * 17)
                                           : 8'($urandom_range(255));
        return r;
    endfunction

    initial begin
        flood_req_t r;
        aresetn            <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_index          <= CFG_SYN_THR;
        cfg_wdata          <= '0;
        m_ready            <= 1'b0;
        s_valid            <= 1'b0;
        s_req_type         <= REQ_PACKET;
        s_src_ip           <= '0;
        s_now_time         <= '0;
        s_pkt_time         <= '0;
        s_transport        <= '0;
        s_src_port         <= '0;
        s_dst_port         <= '0;
        s_packet_size      <= '0;
        s_payload_len      <= '0;
        s_tcp_flags        <= '0;
        s_ike_next_payload <= '0;
        s_block_seconds    <= '0;
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Phase 1: sender idles lightly, receiver stalls half the time.
        // SYN threshold at its floor so ten bare SYNs already alert.
        tx_idle_pct = 9;
        rx_idle_pct = 50;
        set_thresholds(32'd0, 32'hFFFF_FFFF);
        push(pkt(HOT_IP, TR_UDP, PORT_DNS, 16'd20, 8'd0));   // hot source, first_time 1000
        for (int i = 0; i < 10; i++) push(pkt(32'h0A01_0001, TR_TCP, 16'd80, 16'd14, FLAG_SYN));
        push(pkt(32'h0A01_0002, TR_TCP, 16'd80, 16'd13, 8'hFF));          // flags ignored
        push(pkt(32'h0A01_0003, TR_TCP, PORT_OVPN, 16'd0, 8'd0));
        push(pkt(32'h0A01_0004, TR_UDP, PORT_OVPN2, 16'd0, 8'd0));
        push(pkt(32'h0A01_0005, TR_UDP, PORT_WG, 16'd513, 8'd0));         // wide UDP
        push(pkt(32'h0A01_0006, TR_TCP, PORT_WG, 16'd512, 8'd0));         // not WireGuard
        r = pkt(32'h0A01_0007, TR_UDP, PORT_IKE, 16'd8, 8'd0);  r.ike = 8'd0;  push(r);
        r = pkt(32'h0A01_0008, TR_UDP, PORT_IKE_NAT, 16'd7, 8'd0); r.ike = 8'd17; push(r);
        r = pkt(32'h0A01_0009, TR_TCP, 16'd443, 16'd40, FLAG_ACK); r.sport = PORT_SSH; push(r);
        // block lifecycle: drop, then expiry on the first packet past the release time
        push(ctl(REQ_BLOCK, 32'h0A02_0001, 32'd100, 32'd50));
        r = pkt(32'h0A02_0001, TR_UDP, 16'd9, 16'd1, 8'd0); r.now = 32'd150; push(r);
        r.now = 32'd151; push(r);
        push(ctl(REQ_BLOCK, 32'h0A02_0001, 32'hFFFF_FFF0, 32'h100));  // release time saturates
        push(ctl(REQ_BLOCK, 32'h0A02_0001, 32'd5, 32'd5));            // existing entry updated
        push(ctl(REQ_UNBLOCK, 32'h0A02_0001, 32'd0, 32'd0));
        push(ctl(REQ_UNBLOCK, 32'h0A02_0002, 32'd0, 32'd0));          // absent
        push(ctl(2'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF));  // unused type
        r.req = REQ_PACKET; r.ip = 32'hFFFF_FFFF; r.now = '1; r.ptime = '1; r.tr = 2'd3;
        r.sport = '1; r.dport = '1; r.psize = '1; r.plen = '1; r.flags = '1; r.ike = '1;
        r.secs = '1;
        push(r);
        push(ctl(REQ_PACKET, 32'h0, 32'd0, 32'd0));
        for (int i = 0; i < 6; i++) push(random_req());
        drain();

        // Phase 2: the other way round; fill both tables so full results show up.
        tx_idle_pct = 50;
        rx_idle_pct = 9;
        set_thresholds(32'hFFFF_FFFF, 32'd0);
        for (int i = 0; i < 52; i++)
            push(pkt(32'hC0A8_0000 + i, TR_UDP, 16'd9, 16'd1, 8'd0));
        for (int i = 0; i < 17; i++)
            push(ctl(REQ_BLOCK, 32'hB000_0000 + i, 32'd7, 32'hFFFF_FFFF));
        drain();

        // Phase 3: no idling; reset thresholds. The hot source already holds an
        // entry, so its packets still update while the table is full.
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        set_thresholds(SYN_THR_RST, PKT_THR_RST);
        r = pkt(HOT_IP, TR_UDP, PORT_DNS, 16'd20, 8'd0);
        r.ptime = 32'd1001;
        for (int i = 0; i < 2; i++) push(r);
        for (int i = 0; i < 4; i++) push(random_req());
        drain();

        if (sb.errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
